### design/nnt_pkg.sv
// Shared types and constants for the nearest-neighbor tour unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package nnt_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 16;
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned IN_COORD_W      = 16;
  localparam int unsigned VISIT_W         = 4;

  // One loaded point.
  typedef struct packed {
    logic signed [IN_COORD_W-1:0] point_x;
    logic signed [IN_COORD_W-1:0] point_y;
    logic                         final_point;
  } nnt_point_t;

  // One tour position.
  typedef struct packed {
    logic [VISIT_W-1:0] visit_index;
    logic               tour_end;
  } nnt_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_issue;
    logic emit_first;
    logic emit_best;
  } nnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic scan_last;
    logic pipe_busy;
    logic tour_last;
  } nnt_stat_t;

endpackage

`default_nettype wire

### design/nnt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module nnt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/nnt_ctrl.sv
// Sequencer of the nearest-neighbor tour: loading, one scan per tour step, result emission.
// Depends on nnt_pkg for the command and status structs.
`default_nettype none

module nnt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire nnt_pkg::nnt_stat_t stat_i,
  output nnt_pkg::nnt_cmd_t       cmd_o,
  output logic                    busy_o
);
  import nnt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIRST = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } nnt_state_e;

  nnt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.load_last) begin
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd_o.emit_first = 1'b1;
        state_d = stat_i.tour_last ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_best = 1'b1;
        state_d = stat_i.tour_last ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // The final result of a tour frees the block for the next set.
  a_end_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_first || cmd_o.emit_best) && stat_i.tour_last |=> state_q == ST_IDLE)
    else $error("tour did not return to idle after its last result");

  // Results are only produced once the compare pipeline has drained.
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_best |-> !stat_i.pipe_busy)
    else $error("best point taken while candidates still in flight");

endmodule

`default_nettype wire

### design/nnt_dp.sv
// Datapath of the nearest-neighbor tour: point store, distance pipeline, best tracking.
// Depends on nnt_pkg and nnt_ram.
`default_nettype none

module nnt_dp #(
  parameter int unsigned MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nnt_pkg::nnt_cmd_t   cmd_i,
  input  wire nnt_pkg::nnt_point_t point_i,
  output nnt_pkg::nnt_stat_t       stat_o,
  output nnt_pkg::nnt_result_t     result_o,
  output logic                     result_valid_o
);
  import nnt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned EXT_W = IDX_W + VISIT_W;

  // Set bookkeeping.
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      step_q;
  logic [IDX_W-1:0]      scan_q;
  logic [MAX_POINTS-1:0] visited_q;
  logic                  found_q;

  // Pipeline valids (read, abs difference, square).
  logic vr_q, va_q, vm_q;

  // Pipeline payload.
  logic [IDX_W-1:0]      idxr_q, idxa_q, idxm_q;
  logic [COORD_BITS-1:0] xa_q, ya_q, xm_q, ym_q;
  logic [COORD_BITS-1:0] adx_q, ady_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;

  // Current point and best candidate so far.
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [SUM_W-1:0]      best_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q;

  nnt_result_t res_q;
  logic        res_valid_q;

  // Incoming coordinates, sign-extended and then wrapped to the working width.
  logic signed [31:0]      in_x_ext, in_y_ext;
  logic [COORD_BITS-1:0]   in_x, in_y;
  logic [SQ_W-1:0]         ram_wdata, ram_rdata;
  logic [COORD_BITS-1:0]   rx, ry;
  logic [DW-1:0]           dx, dy;
  logic [COORD_BITS-1:0]   adx_d, ady_d;
  logic [SUM_W-1:0]        sum;
  logic                    take, emit, end_tour;
  logic [EXT_W-1:0]        best_ext;

  assign in_x_ext = 32'(point_i.point_x);
  assign in_y_ext = 32'(point_i.point_y);
  assign in_x     = in_x_ext[COORD_BITS-1:0];
  assign in_y     = in_y_ext[COORD_BITS-1:0];
  assign ram_wdata = {in_x, in_y};

  nnt_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign rx = ram_rdata[SQ_W-1:COORD_BITS];
  assign ry = ram_rdata[COORD_BITS-1:0];

  // Differences in one extra bit; the magnitude always fits the coordinate width.
  always_comb begin
    logic [DW-1:0] ndx, ndy;
    dx    = {rx[COORD_BITS-1], rx} - {cur_x_q[COORD_BITS-1], cur_x_q};
    dy    = {ry[COORD_BITS-1], ry} - {cur_y_q[COORD_BITS-1], cur_y_q};
    ndx   = ~dx + 1'b1;
    ndy   = ~dy + 1'b1;
    adx_d = dx[DW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady_d = dy[DW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  end

  // Strict less-than keeps the lowest index on a tie, since indices arrive in order.
  assign sum      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign take     = vm_q && (!found_q || (sum < best_q));
  assign emit     = cmd_i.emit_first || cmd_i.emit_best;
  assign end_tour = emit && stat_o.tour_last;
  assign best_ext = EXT_W'(best_idx_q);

  always_comb begin
    stat_o.load_last = point_i.final_point || (count_q == CNT_W'(MAX_POINTS - 1));
    stat_o.scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
    stat_o.pipe_busy = vr_q || va_q || vm_q;
    stat_o.tour_last = (CNT_W'(step_q) + CNT_W'(1)) == count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      step_q      <= '0;
      scan_q      <= '0;
      visited_q   <= '0;
      found_q     <= 1'b0;
      vr_q        <= 1'b0;
      va_q        <= 1'b0;
      vm_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (end_tour) begin
        count_q <= '0;
      end else if (cmd_i.load) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (end_tour) begin
        step_q <= '0;
      end else if (emit) begin
        step_q <= step_q + IDX_W'(1);
      end
      if (emit) begin
        scan_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (end_tour) begin
        visited_q <= '0;
      end else if (cmd_i.emit_first) begin
        visited_q <= visited_q | MAX_POINTS'(1);
      end else if (cmd_i.emit_best) begin
        visited_q <= visited_q | (MAX_POINTS'(1) << best_idx_q);
      end
      if (emit) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      vr_q        <= cmd_i.scan_issue;
      va_q        <= vr_q && !visited_q[idxr_q];
      vm_q        <= va_q;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    idxr_q <= scan_q;
    idxa_q <= idxr_q;
    xa_q   <= rx;
    ya_q   <= ry;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    idxm_q <= idxa_q;
    xm_q   <= xa_q;
    ym_q   <= ya_q;
    sqx_q  <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q  <= SQ_W'(ady_q) * SQ_W'(ady_q);
    if (take) begin
      best_q     <= sum;
      best_idx_q <= idxm_q;
      best_x_q   <= xm_q;
      best_y_q   <= ym_q;
    end
    if (cmd_i.load && (count_q == '0)) begin
      cur_x_q <= in_x;
      cur_y_q <= in_y;
    end else if (cmd_i.emit_best) begin
      cur_x_q <= best_x_q;
      cur_y_q <= best_y_q;
    end
    if (emit) begin
      res_q.visit_index <= cmd_i.emit_first ? '0 : best_ext[VISIT_W-1:0];
      res_q.tour_end    <= stat_o.tour_last;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  // Every step after the first has at least one unvisited point left.
  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_best |-> found_q)
    else $error("tour step emitted without any candidate");

  // Visited points never reach the compare stage.
  a_skip_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vm_q |-> !visited_q[idxm_q])
    else $error("visited point entered the distance compare");

  // The word that closes a tour also clears the loaded set.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.tour_end |-> (count_q == '0) && (visited_q == '0))
    else $error("point set not cleared at end of tour");

  // The scan never addresses past the loaded points.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> CNT_W'(scan_q) < count_q)
    else $error("scan address beyond loaded points");

endmodule

`default_nettype wire

### design/nearest_neighbour_tour_unit.sv
// Nearest-neighbor tour unit: top level joining the controller and the datapath.
// Depends on nnt_pkg, nnt_ctrl, nnt_dp (and nnt_ram below it).
//
// Points are loaded one word per cycle while busy is low; the word marked final_point,
// or the one that fills the store, starts the tour, and busy rises on the next cycle.
// With n points loaded, index 0 is emitted from the first-result state through the
// result register. Each later index follows a scan that reads all n stored points
// in turn through the single read port of the point store, a drain in which the
// read, difference and square stages empty and the last candidate is compared, and
// an emit step. Each word is on result_o for one cycle with result_valid_o high and
// must be taken then, as there is no back-pressure. busy falls in the cycle that
// carries the last word, whose tour_end bit is set.
`default_nettype none

module nearest_neighbour_tour_unit #(
  parameter int unsigned MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire nnt_pkg::nnt_point_t point_i,
  output logic                     result_valid_o,
  output nnt_pkg::nnt_result_t     result_o
);
  import nnt_pkg::*;

  nnt_cmd_t  cmd;
  nnt_stat_t stat;

  nnt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  nnt_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .point_i        (point_i),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for nearest_neighbour_tour_unit: loads point sets, predicts each
// greedy tour and checks every tour word. Depends on nnt_pkg and the unit's RTL only.
`default_nettype none

module tb;
  import nnt_pkg::*;

  localparam int unsigned PTS         = MAX_POINTS_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN       = 40;
  localparam int unsigned ITEM_GOAL   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  nnt_point_t  point_i = '0;
  logic        result_valid_o;
  nnt_result_t result_o;

  nearest_neighbour_tour_unit #(
    .MAX_POINTS(PTS),
    .COORD_BITS(COORD_BITS_DEF)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .point_i       (point_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Points waiting to be driven, and the tour words still owed by the unit.
  nnt_point_t  pending_pts[$];
  nnt_result_t expected_visits[$];

  // Predictor copy of the point store; coordinates keep the full 16 bits, since
  // COORD_BITS is left at its default and the wrap is then the identity.
  logic signed [IN_COORD_W-1:0] px[PTS];
  logic signed [IN_COORD_W-1:0] py[PTS];
  int unsigned fill_cnt = 0;

  int unsigned words_due = 0;
  int unsigned words_seen = 0;
  int unsigned items_taken = 0;
  int unsigned items_total = 0;
  int unsigned tours_started = 0;
  int unsigned biggest_set = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  bit          tour_wait = 1'b0;

  task automatic report_mismatch(input string msg);
    if (err_count < 30) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Stores one point; when it closes the set, works out the whole greedy tour.
  function automatic bit load_point(input nnt_point_t pt);
    int unsigned n, k, j, cur, best_j;
    longint      dx, dy, dsq, best;
    logic [PTS-1:0] seen;
    bit          found;
    nnt_result_t word;
    px[fill_cnt] = pt.point_x;
    py[fill_cnt] = pt.point_y;
    fill_cnt++;
    if (!pt.final_point && fill_cnt < PTS) return 1'b0;
    n = fill_cnt;
    seen = '0;
    cur = 0;
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        found = 1'b0;
        best = 0;
        best_j = 0;
        for (j = 0; j < n; j++) begin
          if (!seen[j]) begin
            dx = longint'(px[cur]) - longint'(px[j]);
            dy = longint'(py[cur]) - longint'(py[j]);
            dsq = dx * dx + dy * dy;
            // Strict less-than keeps the lowest index on a tie.
            if (!found || dsq < best) begin
              found = 1'b1;
              best = dsq;
              best_j = j;
            end
          end
        end
        cur = best_j;
      end
      seen[cur] = 1'b1;
      word.visit_index = VISIT_W'(cur);
      word.tour_end = (k + 1 == n);
      expected_visits.push_back(word);
    end
    words_due += n;
    tours_started++;
    if (n > biggest_set) biggest_set = n;
    fill_cnt = 0;
    return 1'b1;
  endfunction

  // Gap before the next word; stretches of back-to-back words come in between.
  function automatic int unsigned draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic nnt_point_t make_point(input int sx, input int sy, input bit last);
    nnt_point_t pt;
    pt.point_x = sx[IN_COORD_W-1:0];
    pt.point_y = sy[IN_COORD_W-1:0];
    pt.final_point = last;
    return pt;
  endfunction

  // Driver: after a word that starts a tour, it holds off until the whole tour is back.
  always @(posedge clk_i) begin
    logic drive_go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      drive_go = start;
      if (start && !busy) begin
        if (load_point(point_i)) tour_wait = 1'b1;
        items_taken++;
        drive_go = 1'b0;
        gap_left = draw_gap();
      end
      if (!drive_go) begin
        if (tour_wait && words_seen >= words_due) tour_wait = 1'b0;
        if (!tour_wait) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (pending_pts.size() > 0) begin
            point_i <= pending_pts.pop_front();
            drive_go = 1'b1;
          end
        end
      end
      start <= drive_go;
    end
  end

  // Monitor: every strobed word is checked against the oldest predicted one.
  always @(posedge clk_i) begin
    nnt_result_t want;
    if (rst_ni && result_valid_o) begin
      words_seen <= words_seen + 1;
      if (expected_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected word, index %0d end %0b",
                                  result_o.visit_index, result_o.tour_end));
      end else begin
        want = expected_visits.pop_front();
        if (result_o.visit_index !== want.visit_index)
          report_mismatch($sformatf("visit_index %0d, expected %0d",
                                    result_o.visit_index, want.visit_index));
        if (result_o.tour_end !== want.tour_end)
          report_mismatch($sformatf("tour_end %0b, expected %0b (index %0d)",
                                    result_o.tour_end, want.tour_end, want.visit_index));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned n, i, mode;
    int sx, sy;

    // A single point makes a one-word tour.
    pending_pts.push_back(make_point(0, 0, 1'b1));
    // Coordinate extremes, with distances near the top of the squared range.
    pending_pts.push_back(make_point(-32768, -32768, 1'b0));
    pending_pts.push_back(make_point(32767, 32767, 1'b0));
    pending_pts.push_back(make_point(-32768, 32767, 1'b1));
    // A duplicate point (zero distance) followed by an equal-distance tie.
    pending_pts.push_back(make_point(5, 5, 1'b0));
    pending_pts.push_back(make_point(5, 5, 1'b0));
    pending_pts.push_back(make_point(6, 5, 1'b0));
    pending_pts.push_back(make_point(4, 5, 1'b1));
    // A full store without the final flag: the last point must close the set.
    for (i = 0; i < PTS; i++)
      pending_pts.push_back(make_point((i % 2) ? -32768 + i : 32767 - i,
                                       (i % 3) ? i * 1000 : -i * 1000, 1'b0));

    while (pending_pts.size() < ITEM_GOAL) begin
      i = $urandom_range(0, 9);
      if (i == 0) n = 1;
      else if (i == 9) n = $urandom_range(7, PTS);
      else n = $urandom_range(2, 6);
      mode = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
        case (mode)
          0, 1: begin
            sx = $urandom;
            sy = $urandom;
          end
          // A tiny grid gives many equal distances and repeated points.
          2: begin
            sx = $urandom_range(0, 6) - 3;
            sy = $urandom_range(0, 6) - 3;
          end
          default: begin
            sx = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
            sy = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
          end
        endcase
        // On a full set the flag is drawn freely, since a full store closes it anyway.
        pending_pts.push_back(make_point(sx, sy,
          (i + 1 == n) ? ((n == PTS) ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0));
      end
    end
    items_total = pending_pts.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < items_total || words_seen < words_due) @(negedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (expected_visits.size() != 0)
      report_mismatch($sformatf("%0d tour words never arrived", expected_visits.size()));

    $display("Loaded %0d points into %0d tours (largest %0d points), %0d tour words checked.",
             items_taken, tours_started, biggest_set, words_seen);
    $display("Sets covered single points, extremes, duplicates, ties and full stores.");
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
